FILE: src/s16wd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and layout functions for the Simple16 word decoder.
// No dependencies.
package s16wd_pkg;

  localparam int SEL_W     = 4;
  localparam int PAYLOAD_W = 28;
  localparam int IDX_W     = 5;

  typedef logic [SEL_W-1:0]     sel_t;
  typedef logic [PAYLOAD_W-1:0] payload_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef struct packed {
    sel_t     sel;
    payload_t payload;
    idx_t     last_idx;
    logic     block_end;
  } word_t;

  // Number of fields carried by a word with the given selector, minus one.
  function automatic idx_t field_last_idx(sel_t sel);
    idx_t n;
    unique case (sel)
      4'd0:  n = 5'd27;
      4'd1:  n = 5'd20;
      4'd2:  n = 5'd20;
      4'd3:  n = 5'd20;
      4'd4:  n = 5'd13;
      4'd5:  n = 5'd8;
      4'd6:  n = 5'd7;
      4'd7:  n = 5'd6;
      4'd8:  n = 5'd5;
      4'd9:  n = 5'd5;
      4'd10: n = 5'd4;
      4'd11: n = 5'd4;
      4'd12: n = 5'd3;
      4'd13: n = 5'd2;
      4'd14: n = 5'd1;
      4'd15: n = 5'd0;
    endcase
    return n;
  endfunction

  // Bit width of field number idx, counted from the most significant field.
  function automatic idx_t field_width(sel_t sel, idx_t idx);
    idx_t w;
    unique case (sel)
      4'd0:  w = 5'd1;
      4'd1:  w = (idx < 5'd7) ? 5'd2 : 5'd1;
      4'd2:  w = (idx < 5'd7 || idx >= 5'd14) ? 5'd1 : 5'd2;
      4'd3:  w = (idx < 5'd14) ? 5'd1 : 5'd2;
      4'd4:  w = 5'd2;
      4'd5:  w = (idx == 5'd0) ? 5'd4 : 5'd3;
      4'd6:  w = (idx == 5'd0) ? 5'd3 : ((idx < 5'd5) ? 5'd4 : 5'd3);
      4'd7:  w = 5'd4;
      4'd8:  w = (idx < 5'd4) ? 5'd5 : 5'd4;
      4'd9:  w = (idx < 5'd2) ? 5'd4 : 5'd5;
      4'd10: w = (idx < 5'd3) ? 5'd6 : 5'd5;
      4'd11: w = (idx < 5'd2) ? 5'd5 : 5'd6;
      4'd12: w = 5'd7;
      4'd13: w = (idx == 5'd0) ? 5'd10 : 5'd9;
      4'd14: w = 5'd14;
      4'd15: w = 5'd28;
    endcase
    return w;
  endfunction

endpackage

FILE: src/s16wd_in_if.sv
`timescale 1ns / 1ps
// Input channel of the Simple16 word decoder: one code word per beat.
// No dependencies.
interface s16wd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_word;
  logic        block_end;

  modport source (output valid, output code_word, output block_end, input ready);
  modport sink (input valid, input code_word, input block_end, output ready);
endinterface

FILE: src/s16wd_out_if.sv
`timescale 1ns / 1ps
// Output channel of the Simple16 word decoder: one decoded value per beat.
// No dependencies.
interface s16wd_out_if;
  logic        valid;
  logic        ready;
  logic [27:0] value;
  logic        word_last;
  logic        block_last;

  modport source (output valid, output value, output word_last, output block_last,
                  input ready);
  modport sink (input valid, input value, input word_last, input block_last,
                output ready);
endinterface

FILE: src/s16wd_front.sv
`timescale 1ns / 1ps
// Front stage: accepts code words, splits selector from payload and looks up
// the field count. Depends on s16wd_pkg and s16wd_in_if.
module s16wd_front import s16wd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  s16wd_in_if.sink   words,
  output logic       push,
  output word_t      push_word,
  input  logic       push_ready
);

  logic held;

  assign words.ready = !held || push_ready;
  assign push        = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (words.valid && words.ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (words.valid && words.ready) begin
      push_word.sel       <= words.code_word[31:28];
      push_word.payload   <= words.code_word[27:0];
      push_word.last_idx  <= field_last_idx(words.code_word[31:28]);
      push_word.block_end <= words.block_end;
    end
  end

endmodule

FILE: src/s16wd_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of classified words between the front and back stages.
// Depends on s16wd_pkg.
module s16wd_queue import s16wd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  word_t push_word,
  output logic  push_ready,
  input  logic  pop,
  output logic  head_valid,
  output word_t head
);

  word_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_word;
    end
  end

endmodule

FILE: src/s16wd_back.sv
`timescale 1ns / 1ps
// Back stage: unpacks the current word one field per cycle, unless stalled,
// into the output register. Depends on s16wd_pkg and s16wd_out_if.
module s16wd_back import s16wd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  word_t      head,
  output logic       pop,
  s16wd_out_if.source values
);

  logic     busy;
  word_t    cur;
  idx_t     idx;
  idx_t     width;
  idx_t     shamt;
  payload_t field;
  logic     advance;
  logic     emit;
  logic     emit_last;

  assign width     = field_width(cur.sel, idx);
  assign shamt     = 5'(PAYLOAD_W) - width;
  assign field     = cur.payload >> shamt;
  assign advance   = !values.valid || values.ready;
  assign emit      = busy && advance;
  assign emit_last = emit && (idx == cur.last_idx);
  assign pop       = head_valid && (!busy || emit_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      values.valid <= 1'b0;
    end else begin
      if (advance) begin
        values.valid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (emit_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      idx <= '0;
    end else if (emit) begin
      cur.payload <= cur.payload << width;
      idx         <= idx + 5'd1;
    end
    if (emit) begin
      values.value      <= field;
      values.word_last  <= (idx == cur.last_idx);
      values.block_last <= (idx == cur.last_idx) && cur.block_end;
    end
  end

endmodule

FILE: src/simple16_word_decoder.sv
`timescale 1ns / 1ps
// Simple16 word decoder: top level joining front stage, queue and back stage.
// Depends on s16wd_pkg, the channel interfaces and the s16wd_* stages.
//
// Usage:
//   words carries one 32-bit Simple16 code word per beat, with block_end set
//   on the last word of a compressed block. values carries one decoded field
//   per beat, most significant field first, zero-extended to 28 bits;
//   word_last marks the final field of each word and block_last the final
//   field of a word that came with block_end.
//   An accepted word passes the front register, queue and back-stage word
//   register to reach the output register. The back stage sends one value per
//   cycle while the receiver is ready; a word gives 1 to 28 values. Words are
//   taken back to back while the two-entry queue and front register have room.
//   When the receiver stalls, the output register holds its beat, the back
//   stage waits, and the queue and front register fill before words.ready
//   falls. Synchronous reset empties every stage; no clearing pass is needed.
module simple16_word_decoder import s16wd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  s16wd_in_if.sink    words,
  s16wd_out_if.source values
);

  logic  push;
  word_t push_word;
  logic  push_ready;
  logic  pop;
  logic  head_valid;
  word_t head;

  s16wd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .words      (words),
    .push       (push),
    .push_word  (push_word),
    .push_ready (push_ready)
  );

  s16wd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  s16wd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .values     (values)
  );

endmodule

FILE: src/s16wd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the Simple16 word decoder, bound to the top level.
// Depends on simple16_word_decoder.
module s16wd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [27:0] out_value,
  input logic        out_word_last,
  input logic        out_block_last
);

  a_reset_empties_output: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  a_block_last_on_word_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_block_last |-> out_word_last)
    else $error("block_last without word_last");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value)
      && $stable(out_word_last) && $stable(out_block_last))
    else $error("output beat changed while stalled");

endmodule

bind simple16_word_decoder s16wd_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (words.ready),
  .out_valid      (values.valid),
  .out_ready      (values.ready),
  .out_value      (values.value),
  .out_word_last  (values.word_last),
  .out_block_last (values.block_last)
);

FILE: test/s16wd_checker.sv
`timescale 1ns / 1ps
// Checker for simple16_word_decoder: watches both channels, unpacks each accepted
// code word into its expected values and compares every output beat in order.
// Depends on s16wd_pkg and the two channel interfaces.
module s16wd_scoreboard import s16wd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  s16wd_in_if   words,
  s16wd_out_if  values,
  output int    errors,
  output int    pending
);

  typedef struct packed {
    logic [PAYLOAD_W-1:0] value;
    logic                 word_last;
    logic                 block_last;
  } field_t;

  field_t expected_fields[$];
  int fails = 0;

  assign errors = fails;

  initial pending = 0;

  task automatic note_mismatch(input string what, input field_t want, input field_t got);
    fails++;
    if (fails <= 10) begin
      $display("%0t: %s: expected value %h word_last %b block_last %b,",
               $realtime, what, want.value, want.word_last, want.block_last);
      $display("    got value %h word_last %b block_last %b",
               got.value, got.word_last, got.block_last);
    end
  endtask

  task automatic unpack_word(input logic [31:0] word, input logic blk);
    int cnt [3];
    int wid [3];
    int pos;
    int total;
    int n;
    logic [31:0] bits;
    field_t f;
    case (word[31:28])
      4'd0: begin cnt = '{28, 0, 0}; wid = '{1, 0, 0}; end
      4'd1: begin cnt = '{7, 14, 0}; wid = '{2, 1, 0}; end
      4'd2: begin cnt = '{7, 7, 7}; wid = '{1, 2, 1}; end
      4'd3: begin cnt = '{14, 7, 0}; wid = '{1, 2, 0}; end
      4'd4: begin cnt = '{14, 0, 0}; wid = '{2, 0, 0}; end
      4'd5: begin cnt = '{1, 8, 0}; wid = '{4, 3, 0}; end
      4'd6: begin cnt = '{1, 4, 3}; wid = '{3, 4, 3}; end
      4'd7: begin cnt = '{7, 0, 0}; wid = '{4, 0, 0}; end
      4'd8: begin cnt = '{4, 2, 0}; wid = '{5, 4, 0}; end
      4'd9: begin cnt = '{2, 4, 0}; wid = '{4, 5, 0}; end
      4'd10: begin cnt = '{3, 2, 0}; wid = '{6, 5, 0}; end
      4'd11: begin cnt = '{2, 3, 0}; wid = '{5, 6, 0}; end
      4'd12: begin cnt = '{4, 0, 0}; wid = '{7, 0, 0}; end
      4'd13: begin cnt = '{1, 2, 0}; wid = '{10, 9, 0}; end
      4'd14: begin cnt = '{2, 0, 0}; wid = '{14, 0, 0}; end
      default: begin cnt = '{1, 0, 0}; wid = '{28, 0, 0}; end
    endcase
    total = cnt[0] + cnt[1] + cnt[2];
    pos = PAYLOAD_W;
    n = 0;
    for (int g = 0; g < 3; g++) begin
      for (int i = 0; i < cnt[g]; i++) begin
        pos -= wid[g];
        bits = ({4'd0, word[27:0]} >> pos) & ((32'd1 << wid[g]) - 32'd1);
        f.value = bits[PAYLOAD_W-1:0];
        f.word_last = (n == total - 1);
        f.block_last = (n == total - 1) && blk;
        expected_fields.push_back(f);
        n++;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    field_t want;
    field_t got;
    if (!rst) begin
      if (words.valid && words.ready) begin
        unpack_word(words.code_word, words.block_end);
      end
      if (values.valid && values.ready) begin
        got.value = values.value;
        got.word_last = values.word_last;
        got.block_last = values.block_last;
        if (expected_fields.size() == 0) begin
          note_mismatch("unexpected beat", '0, got);
        end else begin
          want = expected_fields.pop_front();
          if (got.value !== want.value || got.word_last !== want.word_last ||
              got.block_last !== want.block_last) begin
            note_mismatch("wrong beat", want, got);
          end
        end
      end
    end
    pending <= expected_fields.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Testbench top for simple16_word_decoder: clock, reset, code-word stimulus in
// bursts, output back-pressure and the verdict. Depends on s16wd_pkg, the
// channel interfaces, the decoder RTL and s16wd_scoreboard.
module tb import s16wd_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 160;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PERIODIC,
    SINK_CHOKED
  } sink_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sink_ready = 1'b0;
  logic [7:0] sink_cycle = '0;
  sink_mode_t sink_mode = SINK_OPEN;
  int cycle_count = 0;
  int burst_left = 0;
  int mismatches;
  int outstanding;

  s16wd_in_if words ();
  s16wd_out_if values ();

  assign values.ready = sink_ready;

  simple16_word_decoder uut (
    .clk(clk),
    .rst(rst),
    .words(words),
    .values(values)
  );

  s16wd_scoreboard score (
    .clk(clk),
    .rst(rst),
    .words(words),
    .values(values),
    .errors(mismatches),
    .pending(outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    sink_cycle <= sink_cycle + 8'd1;
    if (sink_cycle == 8'd0) begin
      sink_mode <= sink_mode_t'($urandom_range(0, 3));
    end
    case (sink_mode)
      SINK_OPEN: sink_ready <= 1'b1;
      SINK_RANDOM: sink_ready <= ($urandom_range(0, 3) != 0);
      SINK_PERIODIC: sink_ready <= (sink_cycle[1:0] == 2'd0);
      default: sink_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_word(input logic [31:0] word, input logic blk);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        words.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 10);
    end
    words.valid <= 1'b1;
    words.code_word <= word;
    words.block_end <= blk;
    @(posedge clk);
    while (!words.ready) @(posedge clk);
    burst_left--;
  endtask

  initial begin
    logic [31:0] w;
    int sent;
    int blk_len;
    words.valid = 1'b0;
    words.code_word = '0;
    words.block_end = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int s = 0; s < 16; s++) begin
      send_word({4'(s), 28'hFFFFFFF}, 1'(s & 1));
    end
    send_word({4'd0, 28'h0000000}, 1'b1);
    send_word({4'd15, 28'h0000000}, 1'b0);
    send_word({4'd15, 28'h8000001}, 1'b1);
    send_word({4'd2, 28'hAAAAAAA}, 1'b0);
    send_word({4'd13, 28'h5555555}, 1'b1);
    send_word({4'd6, 28'h0123456}, 1'b0);
    send_word({4'd11, 28'hFEDCBA9}, 1'b1);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word($urandom, 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        blk_len = $urandom_range(1, 8);
        for (int k = 0; k < blk_len; k++) begin
          w = $urandom;
          if ($urandom_range(0, 3) == 0) begin
            w[27:0] = w[27:0] << $urandom_range(1, 27);
          end
          send_word(w, k == blk_len - 1);
          sent++;
        end
      end
    end
    words.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
